@@ hdl/bitmap_glyph_rasterizer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap glyph rasterizer assertion macros
// shared concurrent assertion forms for the rasterizer modules
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_RASTERIZER_UNIT_MACROS_SVH
`define BITMAP_GLYPH_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication
`define BGR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bgr_pkg.sv @@
// ----------------------------------------------------------------------------
// bgr_pkg
// types, constants and codes shared by the glyph rasterizer modules
// ----------------------------------------------------------------------------
package bgr_pkg;

   localparam int PANEL_WIDTH  = 240;
   localparam int PANEL_HEIGHT = 240;
   localparam int MAX_GLYPH_W  = 8;
   localparam int MAX_GLYPH_H  = 8;
   localparam int FONT_BYTES   = 1024;

   localparam int DIM_W   = 4;
   localparam int COORD_W = 8;
   localparam int COLOR_W = 16;
   localparam int LOC_W   = 3;
   localparam int IDX_W   = 7;
   localparam int PROD_W  = IDX_W + DIM_W;

   localparam logic [7:0] CODE_FIRST = 8'h20;
   localparam logic [7:0] CODE_LAST  = 8'h7E;
   localparam logic [7:0] CODE_SUBST = 8'h3F;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   localparam logic [1:0] CSR_GLYPH_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GLYPH_HEIGHT = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_LOAD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
   } ctx_type;

   typedef struct packed {
      logic load;
      logic run;
      logic last_row;
   } pg_ctrl_type;

   typedef struct packed {
      logic fire;
      logic row_end;
   } pg_stat_type;

endpackage

@@ hdl/bgr_addr_mul.sv @@
// ----------------------------------------------------------------------------
// bgr_addr_mul
// bit-serial shift-add multiplier for the glyph base address
// ----------------------------------------------------------------------------
module bgr_addr_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bgr_pkg::IDX_W-1:0]   mcand,
   input  logic [bgr_pkg::DIM_W-1:0]   mplier,
   output logic                        busy,
   output logic [bgr_pkg::PROD_W-1:0]  product
);

   logic                        busy_ff,   busy_in;
   logic [bgr_pkg::PROD_W-1:0]  acc_ff,    acc_in;
   logic [bgr_pkg::PROD_W-1:0]  mcand_ff,  mcand_in;
   logic [bgr_pkg::DIM_W-1:0]   mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         acc_in    = '0;
         mcand_in  = bgr_pkg::PROD_W'(mcand);
         mplier_in = mplier;
         busy_in   = (mplier != '0);
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[bgr_pkg::PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[bgr_pkg::DIM_W-1:1]};
         busy_in   = (mplier_ff[bgr_pkg::DIM_W-1:1] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

@@ hdl/bgr_font_store.sv @@
// ----------------------------------------------------------------------------
// bgr_font_store
// font byte memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bgr_font_store #(
   parameter int FONT_BYTES = bgr_pkg::FONT_BYTES
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [9:0]                  wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [bgr_pkg::PROD_W-1:0]  rd_addr,
   output logic [7:0]                  rd_data
);

   localparam int AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;

   logic [7:0]    mem [FONT_BYTES];
   logic [7:0]    rd_data_ff;
   logic          rd_oor_ff;
   logic          wr_ok;
   logic          rd_oor;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] rd_idx;

   assign wr_ok  = (32'(wr_addr) < FONT_BYTES);
   assign rd_oor = (32'(rd_addr) >= FONT_BYTES);
   assign wr_idx = AW'(wr_addr);
   assign rd_idx = AW'(rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_oor_ff <= rd_oor;
         if (!rd_oor) begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

   // bytes past the end of the store read as blank
   assign rd_data = rd_oor_ff ? 8'h00 : rd_data_ff;

endmodule

@@ hdl/bgr_pixel_gen.sv @@
// ----------------------------------------------------------------------------
// bgr_pixel_gen
// row shift register, column counter and result output register
// ----------------------------------------------------------------------------
`include "bitmap_glyph_rasterizer_unit_macros.svh"

module bgr_pixel_gen (
   input  logic                         clock,
   input  logic                         reset,
   input  bgr_pkg::pg_ctrl_type         ctrl,
   input  bgr_pkg::ctx_type             ctx,
   input  logic [bgr_pkg::LOC_W-1:0]    row,
   input  logic [7:0]                   font_byte,
   output bgr_pkg::pg_stat_type         stat,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bgr_pkg::COLOR_W-1:0]  rsp_pixel_color,
   output logic [bgr_pkg::LOC_W-1:0]    rsp_col_index,
   output logic [bgr_pkg::LOC_W-1:0]    rsp_row_index,
   output logic [bgr_pkg::DIM_W-1:0]    rsp_clip_width,
   output logic [bgr_pkg::DIM_W-1:0]    rsp_clip_height,
   output logic                         rsp_last_pixel
);

   logic [7:0]                   shreg_ff, shreg_in;
   logic [bgr_pkg::LOC_W-1:0]    col_ff,   col_in;
   logic                         valid_ff, valid_in;
   logic [bgr_pkg::COLOR_W-1:0]  color_ff;
   logic [bgr_pkg::LOC_W-1:0]    col_out_ff;
   logic [bgr_pkg::LOC_W-1:0]    row_out_ff;
   logic [bgr_pkg::DIM_W-1:0]    width_ff;
   logic [bgr_pkg::DIM_W-1:0]    height_ff;
   logic                         last_ff;
   logic                         adv;
   logic                         fire;
   logic                         row_end;

   assign adv     = !valid_ff || !rsp_stall;
   assign fire    = ctrl.run && adv;
   assign row_end = ({1'b0, col_ff} == (ctx.width - 4'd1));

   always_comb begin
      shreg_in = shreg_ff;
      col_in   = col_ff;
      if (ctrl.load) begin
         shreg_in = font_byte;
         col_in   = '0;
      end else if (fire) begin
         shreg_in = {shreg_ff[6:0], 1'b0};
         col_in   = row_end ? '0 : col_ff + 3'd1;
      end
   end

   always_comb begin
      if (fire) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         col_ff   <= col_in;
      end
      shreg_ff <= shreg_in;
      if (fire) begin
         color_ff   <= shreg_ff[7] ? ctx.fg : ctx.bg;
         col_out_ff <= col_ff;
         row_out_ff <= row;
         width_ff   <= ctx.width;
         height_ff  <= ctx.height;
         last_ff    <= ctrl.last_row && row_end;
      end
   end

   assign stat.fire       = fire;
   assign stat.row_end    = row_end;
   assign rsp_valid       = valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_col_index   = col_out_ff;
   assign rsp_row_index   = row_out_ff;
   assign rsp_clip_width  = width_ff;
   assign rsp_clip_height = height_ff;
   assign rsp_last_pixel  = last_ff;

   `BGR_ASSERT_NOW(a_col_in_clip, clock, reset, valid_ff, ({1'b0, col_out_ff} < width_ff), "column outside clipped width")
   `BGR_ASSERT_NOW(a_last_at_corner, clock, reset, valid_ff, (last_ff == (({1'b0, col_out_ff} == width_ff - 4'd1) && ({1'b0, row_out_ff} == height_ff - 4'd1))), "last pixel flag not at glyph corner")

endmodule

@@ hdl/bitmap_glyph_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_rasterizer_unit
// character generator: font byte loads and clipped glyph pixel streams
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | moves
//  req     | in        | req_valid/stall    | font load or draw command
//  rsp     | out       | rsp_valid/stall    | one pixel per transfer
//  csr     | in        | csr_valid/ready    | glyph width or height write
//
//  load, and an off-screen or empty draw, are taken without leaving idle.
//  draw: a serial base multiply over the bits of the glyph height, then the
//  rows of the clipped glyph.
//  each row costs one font read and one shift register load, then one pixel
//  a cycle shifted out msb first while rsp_stall is low.
//  reset is synchronous; the font store keeps its contents and is not cleared.
//  rsp_stall freezes pixel shifting; req_stall is low only while idle.
// ----------------------------------------------------------------------------
`include "bitmap_glyph_rasterizer_unit_macros.svh"

module bitmap_glyph_rasterizer_unit #(
   parameter int FONT_BYTES = bgr_pkg::FONT_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [9:0]                   req_table_addr,
   input  logic [7:0]                   req_table_byte,
   input  logic [7:0]                   req_char_code,
   input  logic [bgr_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [bgr_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [bgr_pkg::COLOR_W-1:0]  req_fg_color,
   input  logic [bgr_pkg::COLOR_W-1:0]  req_bg_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bgr_pkg::COLOR_W-1:0]  rsp_pixel_color,
   output logic [bgr_pkg::LOC_W-1:0]    rsp_col_index,
   output logic [bgr_pkg::LOC_W-1:0]    rsp_row_index,
   output logic [bgr_pkg::DIM_W-1:0]    rsp_clip_width,
   output logic [bgr_pkg::DIM_W-1:0]    rsp_clip_height,
   output logic                         rsp_last_pixel,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [bgr_pkg::DIM_W-1:0]    csr_data
);

   localparam logic [8:0] PANEL_W = 9'(bgr_pkg::PANEL_WIDTH);
   localparam logic [8:0] PANEL_H = 9'(bgr_pkg::PANEL_HEIGHT);
   localparam logic [bgr_pkg::DIM_W-1:0] MAX_W = bgr_pkg::DIM_W'(bgr_pkg::MAX_GLYPH_W);
   localparam logic [bgr_pkg::DIM_W-1:0] MAX_H = bgr_pkg::DIM_W'(bgr_pkg::MAX_GLYPH_H);

   bgr_pkg::state_type           state_ff, state_in;
   bgr_pkg::ctx_type             ctx_ff,   ctx_in;
   logic [bgr_pkg::LOC_W-1:0]    row_ff,   row_in;
   logic [bgr_pkg::DIM_W-1:0]    gw_ff;
   logic [bgr_pkg::DIM_W-1:0]    gh_ff;

   logic                         accept;
   logic                         load_wr;
   logic                         off_x;
   logic                         off_y;
   logic [8:0]                   room_x;
   logic [8:0]                   room_y;
   logic [bgr_pkg::DIM_W-1:0]    gw_sat;
   logic [bgr_pkg::DIM_W-1:0]    gh_sat;
   logic [bgr_pkg::DIM_W-1:0]    clip_w;
   logic [bgr_pkg::DIM_W-1:0]    clip_h;
   logic                         empty;
   logic                         unsupported;
   logic [7:0]                   code_sel;
   logic [bgr_pkg::IDX_W-1:0]    glyph_idx;
   logic                         mul_start;
   logic                         mul_busy;
   logic [bgr_pkg::PROD_W-1:0]   base_addr;
   logic [bgr_pkg::PROD_W-1:0]   rd_addr;
   logic [7:0]                   rd_data;
   logic                         last_row;
   bgr_pkg::pg_ctrl_type         pg_ctrl;
   bgr_pkg::pg_stat_type         pg_stat;

   assign req_stall = (state_ff != bgr_pkg::ST_IDLE);
   assign csr_ready = (state_ff == bgr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_wr   = accept && (req_type == bgr_pkg::REQ_LOAD);

   // glyph geometry and clipping
   assign off_x  = ({1'b0, req_pos_x} >= PANEL_W);
   assign off_y  = ({1'b0, req_pos_y} >= PANEL_H);
   assign room_x = PANEL_W - {1'b0, req_pos_x};
   assign room_y = PANEL_H - {1'b0, req_pos_y};
   assign gw_sat = (gw_ff > MAX_W) ? MAX_W : gw_ff;
   assign gh_sat = (gh_ff > MAX_H) ? MAX_H : gh_ff;
   assign clip_w = (room_x < {5'd0, gw_sat}) ? room_x[3:0] : gw_sat;
   assign clip_h = (room_y < {5'd0, gh_sat}) ? room_y[3:0] : gh_sat;
   assign empty  = off_x || off_y || (clip_w == '0) || (clip_h == '0);

   assign unsupported = (req_char_code < bgr_pkg::CODE_FIRST) ||
                        (req_char_code > bgr_pkg::CODE_LAST);
   assign code_sel    = unsupported ? bgr_pkg::CODE_SUBST : req_char_code;
   assign glyph_idx   = bgr_pkg::IDX_W'(code_sel - bgr_pkg::CODE_FIRST);

   assign mul_start = accept && (req_type == bgr_pkg::REQ_DRAW) && !empty;
   assign rd_addr   = base_addr + bgr_pkg::PROD_W'(row_ff);
   assign last_row  = ({1'b0, row_ff} == (ctx_ff.height - 4'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= MAX_W;
         gh_ff <= MAX_H;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bgr_pkg::CSR_GLYPH_WIDTH:  gw_ff <= csr_data;
            bgr_pkg::CSR_GLYPH_HEIGHT: gh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      row_in   = row_ff;
      pg_ctrl  = '0;
      unique case (state_ff)
         bgr_pkg::ST_IDLE: begin
            if (mul_start) begin
               ctx_in.width  = clip_w;
               ctx_in.height = clip_h;
               ctx_in.fg     = unsupported ? req_bg_color : req_fg_color;
               ctx_in.bg     = unsupported ? req_fg_color : req_bg_color;
               row_in        = '0;
               state_in      = bgr_pkg::ST_MUL;
            end
         end
         bgr_pkg::ST_MUL: begin
            if (!mul_busy) begin
               state_in = bgr_pkg::ST_FETCH;
            end
         end
         bgr_pkg::ST_FETCH: begin
            state_in = bgr_pkg::ST_LOAD;
         end
         bgr_pkg::ST_LOAD: begin
            pg_ctrl.load = 1'b1;
            state_in     = bgr_pkg::ST_EMIT;
         end
         bgr_pkg::ST_EMIT: begin
            pg_ctrl.run      = 1'b1;
            pg_ctrl.last_row = last_row;
            if (pg_stat.fire && pg_stat.row_end) begin
               if (last_row) begin
                  state_in = bgr_pkg::ST_IDLE;
               end else begin
                  row_in   = row_ff + 3'd1;
                  state_in = bgr_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = bgr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgr_pkg::ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
      ctx_ff <= ctx_in;
   end

   bgr_addr_mul u_addr_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (glyph_idx),
      .mplier  (gh_sat),
      .busy    (mul_busy),
      .product (base_addr)
   );

   bgr_font_store #(
      .FONT_BYTES (FONT_BYTES)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_table_addr),
      .wr_data (req_table_byte),
      .rd_en   (state_ff == bgr_pkg::ST_FETCH),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bgr_pixel_gen u_pixel_gen (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (pg_ctrl),
      .ctx             (ctx_ff),
      .row             (row_ff),
      .font_byte       (rd_data),
      .stat            (pg_stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_col_index   (rsp_col_index),
      .rsp_row_index   (rsp_row_index),
      .rsp_clip_width  (rsp_clip_width),
      .rsp_clip_height (rsp_clip_height),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   `BGR_ASSERT_NEXT(a_draw_starts_mul, clock, reset, mul_start, ((state_ff == bgr_pkg::ST_MUL) && mul_busy), "draw transfer did not start the base multiply")
   `BGR_ASSERT_NOW(a_row_in_clip, clock, reset, (state_ff == bgr_pkg::ST_FETCH) || (state_ff == bgr_pkg::ST_EMIT), ({1'b0, row_ff} < ctx_ff.height), "row counter outside clipped height")

endmodule

@@ tb/sv/tb_bitmap_glyph_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_glyph_rasterizer_unit
// self-checking bench for the glyph rasterizer: font byte loads and draw
// commands go in, the clipped pixel stream coming out is compared pixel by
// pixel against a behavioral rasterizer kept in the bench. a directed table
// covers field extremes, clipping at the panel edges, off-screen positions
// and the substitute glyph for unsupported codes; random traffic follows
// over several glyph sizes (zero and oversized among them) with random
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bitmap_glyph_rasterizer_unit;
   import bgr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int QUIET_CYCLES   = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int NUM_DIRECTED   = 22;
   localparam int NUM_PHASES     = 10;

   typedef struct packed {
      logic               kind;
      logic [9:0]         addr;
      logic [7:0]         data;
      logic [7:0]         code;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
   } glyph_req_t;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [LOC_W-1:0]   col;
      logic [LOC_W-1:0]   row;
      logic [DIM_W-1:0]   cw;
      logic [DIM_W-1:0]   ch;
      logic               last;
   } pixel_t;

   typedef struct {
      int n;
      int w;
      int h;
   } check_t;

   typedef struct {
      logic kind;
      int   addr;
      int   data;
      int   code;
      int   x;
      int   y;
      int   fg;
      int   bg;
      int   n;
      int   w;
      int   h;
   } dir_row_t;

   typedef struct {
      int w;
      int h;
      int send_pct;
      int stall_pct;
      int items;
      bit pressure;
   } phase_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = REQ_LOAD;
   logic [9:0]         req_table_addr = '0;
   logic [7:0]         req_table_byte = '0;
   logic [7:0]         req_char_code = '0;
   logic [COORD_W-1:0] req_pos_x = '0;
   logic [COORD_W-1:0] req_pos_y = '0;
   logic [COLOR_W-1:0] req_fg_color = '0;
   logic [COLOR_W-1:0] req_bg_color = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COLOR_W-1:0] rsp_pixel_color;
   logic [LOC_W-1:0]   rsp_col_index;
   logic [LOC_W-1:0]   rsp_row_index;
   logic [DIM_W-1:0]   rsp_clip_width;
   logic [DIM_W-1:0]   rsp_clip_height;
   logic               rsp_last_pixel;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_GLYPH_WIDTH;
   logic [DIM_W-1:0]   csr_data = '0;

   bitmap_glyph_rasterizer_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_table_addr  (req_table_addr),
      .req_table_byte  (req_table_byte),
      .req_char_code   (req_char_code),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_col_index   (rsp_col_index),
      .rsp_row_index   (rsp_row_index),
      .rsp_clip_width  (rsp_clip_width),
      .rsp_clip_height (rsp_clip_height),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // behavioral rasterizer state
   logic [7:0]       font_m [FONT_BYTES];
   logic [DIM_W-1:0] glyph_w_m = 4'd8;
   logic [DIM_W-1:0] glyph_h_m = 4'd8;
   pixel_t           expected_pixels [$];
   check_t           directed_sizes [$];

   // stimulus side bookkeeping
   bit     font_written [FONT_BYTES];
   int     glyph_w_set = 8;
   int     glyph_h_set = 8;
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   logic   rsp_hold = 1'b0;
   event   hold_ev;
   check_t unchecked = '{-1, -1, -1};

   int mismatches = 0;
   int n_loads = 0;
   int n_draws = 0;
   int n_pixels = 0;
   int quiet_cycles = 0;

   glyph_req_t seen;
   check_t     seen_chk;
   int         got_n, got_w, got_h;
   pixel_t     want;

   dir_row_t directed [NUM_DIRECTED] = '{
      '{REQ_LOAD,    0, 'hFF,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_LOAD,    1, 'h80,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_LOAD,    2, 'h01,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_LOAD,    3, 'h00,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_LOAD, 1023, 'hA5,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_DRAW,    0,    0, 'h20,   0,   0, 'hFFFF, 'h0000, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h7E,   0,   0, 'h0000, 'hFFFF, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h00,  16,  16, 'hF800, 'h001F, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'hFF,  24,  24, 'h07E0, 'hFFFF, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h1F,  32,  32, 'h1111, 'h2222, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h7F,  40,  40, 'h3333, 'h4444, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h41, 239,   0, 'hAAAA, 'h5555,  8, 1, 8},
      '{REQ_DRAW,    0,    0, 'h41,   0, 239, 'h5555, 'hAAAA,  8, 8, 1},
      '{REQ_DRAW,    0,    0, 'h41, 239, 239, 'hFFFF, 'h0000,  1, 1, 1},
      '{REQ_DRAW,    0,    0, 'h5A, 232, 232, 'h0F0F, 'hF0F0, 64, 8, 8},
      '{REQ_DRAW,    0,    0, 'h5A, 233, 100, 'h00FF, 'hFF00, 56, 7, 8},
      '{REQ_DRAW,    0,    0, 'h30, 240,   0, 'hFFFF, 'hFFFF,  0, 0, 0},
      '{REQ_DRAW,    0,    0, 'h30,   0, 240, 'hFFFF, 'hFFFF,  0, 0, 0},
      '{REQ_DRAW,    0,    0, 'h30, 255, 255, 'hFFFF, 'hFFFF,  0, 0, 0},
      '{REQ_DRAW,    0,    0, 'h80, 128,  64, 'h1234, 'hABCD, -1, -1, -1},
      '{REQ_LOAD,  264, 'h3C,    0,   0,   0,      0,      0,  0, 0, 0},
      '{REQ_DRAW,    0,    0, 'h41, 100,  50, 'h1234, 'hABCD, -1, -1, -1}
   };

   phase_t phases [NUM_PHASES] = '{
      '{ 8,  8,  0,  0, 12, 1'b0},
      '{15, 15, 64,  0, 14, 1'b0},
      '{ 0,  8,  0, 64,  6, 1'b0},
      '{ 1,  1, 12, 12, 14, 1'b0},
      '{ 3,  5,  0,  0, 14, 1'b1},
      '{ 8,  0, 64,  0,  6, 1'b0},
      '{ 5,  7,  0, 64, 14, 1'b0},
      '{ 1,  8, 12, 12, 14, 1'b0},
      '{ 8,  1,  0, 64, 12, 1'b0},
      '{ 2, 15, 12, 12, 12, 1'b0}
   };

   initial forever #6 clock = ~clock;

   task automatic flag_mismatch(input string what, input int got, input int exp_val);
      if (mismatches < 40)
         $display("mismatch %s: got 0x%0h, want 0x%0h at %0t ns", what, got, exp_val, $time);
      mismatches++;
   endtask

   // expected pixels of one accepted item, row-major, msb of each font byte first
   task automatic rasterize_glyph(input glyph_req_t r, output int n, output int cw,
                                  output int ch);
      logic [7:0]         code;
      logic [7:0]         bits;
      logic [COLOR_W-1:0] fg, bg;
      int                 gw, gh, stride, base, adr;
      pixel_t             px;
      n  = 0;
      cw = 0;
      ch = 0;
      if (r.kind == REQ_LOAD) begin
         if (int'(r.addr) < FONT_BYTES)
            font_m[r.addr] = r.data;
         return;
      end
      if (int'(r.x) >= PANEL_WIDTH || int'(r.y) >= PANEL_HEIGHT)
         return;
      code = r.code;
      fg   = r.fg;
      bg   = r.bg;
      if (code < CODE_FIRST || code > CODE_LAST) begin
         code = CODE_SUBST;
         fg   = r.bg;
         bg   = r.fg;
      end
      gw     = (int'(glyph_w_m) > MAX_GLYPH_W) ? MAX_GLYPH_W : int'(glyph_w_m);
      gh     = (int'(glyph_h_m) > MAX_GLYPH_H) ? MAX_GLYPH_H : int'(glyph_h_m);
      stride = (gw + 7) / 8;
      cw     = gw;
      ch     = gh;
      if (int'(r.x) + cw > PANEL_WIDTH)
         cw = PANEL_WIDTH - int'(r.x);
      if (int'(r.y) + ch > PANEL_HEIGHT)
         ch = PANEL_HEIGHT - int'(r.y);
      if (cw == 0 || ch == 0) begin
         cw = 0;
         ch = 0;
         return;
      end
      base = (int'(code) - int'(CODE_FIRST)) * gh * stride;
      for (int j = 0; j < ch; j++) begin
         for (int i = 0; i < cw; i++) begin
            adr      = base + j * stride + i / 8;
            bits     = (adr < FONT_BYTES) ? font_m[adr] : 8'h00;
            px.color = bits[7 - (i % 8)] ? fg : bg;
            px.col   = 3'(i);
            px.row   = 3'(j);
            px.cw    = 4'(cw);
            px.ch    = 4'(ch);
            px.last  = (j == ch - 1) && (i == cw - 1);
            expected_pixels.push_back(px);
            n++;
         end
      end
   endtask

   // monitors: accepted requests, register writes and pixel transfers
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         seen.kind = req_type;
         seen.addr = req_table_addr;
         seen.data = req_table_byte;
         seen.code = req_char_code;
         seen.x    = req_pos_x;
         seen.y    = req_pos_y;
         seen.fg   = req_fg_color;
         seen.bg   = req_bg_color;
         rasterize_glyph(seen, got_n, got_w, got_h);
         if (req_type == REQ_LOAD)
            n_loads++;
         else
            n_draws++;
         seen_chk = (directed_sizes.size() != 0) ? directed_sizes.pop_front() : unchecked;
         if (seen_chk.n >= 0) begin
            if (got_n != seen_chk.n)
               flag_mismatch("directed pixel count", got_n, seen_chk.n);
            if (got_w != seen_chk.w || got_h != seen_chk.h)
               flag_mismatch("directed clip size", got_w * 16 + got_h,
                             seen_chk.w * 16 + seen_chk.h);
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_GLYPH_WIDTH)
            glyph_w_m = csr_data;
         else if (csr_index == CSR_GLYPH_HEIGHT)
            glyph_h_m = csr_data;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         n_pixels++;
         if (expected_pixels.size() == 0) begin
            flag_mismatch("pixel with nothing expected", rsp_pixel_color, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_color !== want.color)
               flag_mismatch("pixel_color", rsp_pixel_color, want.color);
            if (rsp_col_index !== want.col)
               flag_mismatch("col_index", rsp_col_index, want.col);
            if (rsp_row_index !== want.row)
               flag_mismatch("row_index", rsp_row_index, want.row);
            if (rsp_clip_width !== want.cw)
               flag_mismatch("clip_width", rsp_clip_width, want.cw);
            if (rsp_clip_height !== want.ch)
               flag_mismatch("clip_height", rsp_clip_height, want.ch);
            if (rsp_last_pixel !== want.last)
               flag_mismatch("last_pixel", rsp_last_pixel, want.last);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial forever begin
      @(hold_ev);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("bitmap_glyph_rasterizer_unit regression: fail");
         $finish;
      end
   end

   task automatic offer(input glyph_req_t r, input check_t chk);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      directed_sizes.push_back(chk);
      req_valid      <= 1'b1;
      req_type       <= r.kind;
      req_table_addr <= r.addr;
      req_table_byte <= r.data;
      req_char_code  <= r.code;
      req_pos_x      <= r.x;
      req_pos_y      <= r.y;
      req_fg_color   <= r.fg;
      req_bg_color   <= r.bg;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_load(input int addr, input int data, input check_t chk);
      glyph_req_t r;
      r      = '0;
      r.kind = REQ_LOAD;
      r.addr = 10'(addr);
      r.data = 8'(data);
      r.code = 8'($urandom_range(255));
      r.x    = 8'($urandom_range(255));
      r.y    = 8'($urandom_range(255));
      font_written[addr] = 1'b1;
      offer(r, chk);
   endtask

   // every font byte of the glyph gets written before the draw can read it
   task automatic send_draw(input logic [7:0] code, input logic [7:0] x, input logic [7:0] y,
                            input logic [15:0] fg, input logic [15:0] bg, input check_t chk);
      glyph_req_t r;
      logic [7:0] shown;
      int         gw, gh, stride, base;
      shown  = (code < CODE_FIRST || code > CODE_LAST) ? CODE_SUBST : code;
      gw     = (glyph_w_set > MAX_GLYPH_W) ? MAX_GLYPH_W : glyph_w_set;
      gh     = (glyph_h_set > MAX_GLYPH_H) ? MAX_GLYPH_H : glyph_h_set;
      stride = (gw + 7) / 8;
      base   = (int'(shown) - int'(CODE_FIRST)) * gh * stride;
      for (int k = 0; k < gh * stride; k++)
         if (!font_written[base + k])
            send_load(base + k, $urandom_range(255), unchecked);
      r      = '0;
      r.kind = REQ_DRAW;
      r.addr = 10'($urandom_range(1023));
      r.data = 8'($urandom_range(255));
      r.code = code;
      r.x    = x;
      r.y    = y;
      r.fg   = fg;
      r.bg   = bg;
      offer(r, chk);
   endtask

   function automatic logic [7:0] pick_coord();
      case ($urandom_range(9))
         0: return 8'($urandom_range(255, 228));
         1: return 8'($urandom_range(7));
         default: return 8'($urandom_range(239));
      endcase
   endfunction

   task automatic random_item();
      logic [7:0] code;
      if ($urandom_range(99) < 20) begin
         send_load($urandom_range(1023), $urandom_range(255), unchecked);
      end else begin
         if ($urandom_range(3) == 0)
            code = 8'($urandom_range(255));
         else
            code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
         send_draw(code, pick_coord(), pick_coord(), 16'($urandom), 16'($urandom), unchecked);
      end
   endtask

   // wait for the pixel stream to drain and the block to go idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic program_glyph_size(input int w, input int h);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_GLYPH_WIDTH;
      csr_data  <= 4'(w);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_GLYPH_HEIGHT;
      csr_data  <= 4'(h);
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      glyph_w_set = w;
      glyph_h_set = h;
   endtask

   initial begin
      check_t chk;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         chk = '{directed[k].n, directed[k].w, directed[k].h};
         if (directed[k].kind == REQ_LOAD)
            send_load(directed[k].addr, directed[k].data, chk);
         else
            send_draw(8'(directed[k].code), 8'(directed[k].x), 8'(directed[k].y),
                      16'(directed[k].fg), 16'(directed[k].bg), chk);
      end

      foreach (phases[p]) begin
         if (p != 0)
            program_glyph_size(phases[p].w, phases[p].h);
         send_idle_pct = phases[p].send_pct;
         stall_pct     = phases[p].stall_pct;
         if (phases[p].pressure)
            -> hold_ev;
         repeat (phases[p].items) random_item();
      end

      settle();
      $display("run covered %0d font byte loads and %0d draws, %0d pixels compared",
               n_loads, n_draws, n_pixels);
      $display("over %0d glyph size settings from 0 to 15, panel edge clipping and back-pressure",
               NUM_PHASES);
      if (mismatches == 0)
         $display("bitmap_glyph_rasterizer_unit regression: pass");
      else
         $display("bitmap_glyph_rasterizer_unit regression: fail");
      $finish;
   end

endmodule

@@ bitmap_glyph_rasterizer_unit.f @@
+incdir+hdl
hdl/bgr_pkg.sv
hdl/bgr_addr_mul.sv
hdl/bgr_font_store.sv
hdl/bgr_pixel_gen.sv
hdl/bitmap_glyph_rasterizer_unit.sv
tb/sv/tb_bitmap_glyph_rasterizer_unit.sv
